[hw/rtl/mck_pkg.sv]
`default_nettype none

package mck_pkg;

  localparam int FIFO_DEPTH = 64;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int UNIT_W = 12;
  localparam int PER_W  = 15;
  localparam int PAT_W  = 5;
  localparam int LEN_W  = 3;

  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_CLR  = 2'd2;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  localparam logic [PAT_W-1:0] ALPHA_PAT [26] = '{
    5'h02, 5'h01, 5'h05, 5'h01, 5'h00, 5'h04, 5'h03, 5'h00, 5'h00, 5'h0E, 5'h05, 5'h02,
    5'h03, 5'h01, 5'h07, 5'h06, 5'h0B, 5'h02, 5'h00, 5'h01, 5'h04, 5'h08, 5'h06, 5'h09,
    5'h0D, 5'h03
  };

  localparam logic [LEN_W-1:0] ALPHA_LEN [26] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  localparam logic [PAT_W-1:0] DIGIT_PAT [10] = '{
    5'h1F, 5'h1E, 5'h1C, 5'h18, 5'h10, 5'h00, 5'h01, 5'h03, 5'h07, 5'h0F
  };

  localparam logic [LEN_W-1:0] DIGIT_LEN = 3'd5;

  typedef enum logic [5:0] {
    PH_SYM     = 6'b000001,
    PH_SYMGAP  = 6'b000010,
    PH_LETGAP  = 6'b000100,
    PH_WORDGAP = 6'b001000,
    PH_FINAL   = 6'b010000,
    PH_DONE    = 6'b100000
  } ph_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_sts_t;

endpackage

`default_nettype wire

[hw/rtl/mck_ram.sv]
`default_nettype none

module mck_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/mck_fifo.sv]
`default_nettype none

module mck_fifo
  import mck_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire fifo_ctl_t ctl,
  input  wire logic [7:0] wr_data,
  output fifo_sts_t      sts,
  output logic [7:0]     head_data
);

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             byp_r, byp_nxt;
  logic [7:0]       byp_data_r;
  logic [7:0]       ram_q;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (ctl.pop) begin
      head_nxt = (head_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
      cnt_nxt  = cnt_nxt - 1'b1;
    end
    if (ctl.push) begin
      tail_nxt = (tail_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      cnt_nxt  = cnt_nxt + 1'b1;
    end
    // same-cycle write to the entry being fetched
    byp_nxt = ctl.push && (tail_r == head_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      byp_r  <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      byp_r  <= byp_nxt;
    end
    byp_data_r <= wr_data;
  end

  mck_ram #(
    .WIDTH(8),
    .DEPTH(FIFO_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ctl.push),
    .waddr(tail_r),
    .wdata(wr_data),
    .raddr(head_nxt),
    .rdata(ram_q)
  );

  assign head_data = byp_r ? byp_data_r : ram_q;
  assign sts.empty = (cnt_r == '0);
  assign sts.full  = (cnt_r == CNT_W'(FIFO_DEPTH));

endmodule

`default_nettype wire

[hw/rtl/morse_code_keyer_tx.sv]
// Morse keyer, transmit side. Every item (a received byte, a timer tick or a
// switch-flag clear) gives exactly one result that shows the key level, the
// idle state, the switch flag and whether that byte was dropped. One item is
// taken per clock unless the output stalls; an accepted item goes through the
// input register, then the result register, and the state update sits in the
// single logic stage between them. The 64-character queue lives in a RAM
// with a registered read that always prefetches the head entry, so a pop in
// every cycle is possible. No clearing pass is needed after reset.
// cfg_wr_data sets the ticks per Morse unit; zero is timed as one.
`default_nettype none

module morse_code_keyer_tx
  import mck_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [11:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_key_on,
  output logic             out_idle,
  output logic             out_switch_requested,
  output logic             out_byte_dropped
);

  typedef struct packed {
    ph_t              ph;
    logic [PAT_W-1:0] pat;
    logic [LEN_W-1:0] left;
  } kst_t;

  function automatic kst_t load_char(logic [7:0] c, ph_t ph, logic [PAT_W-1:0] pat,
                                     logic [LEN_W-1:0] left);
    kst_t       r;
    logic [4:0] idx;
    logic       first;
    r.ph   = ph;
    r.pat  = pat;
    r.left = left;
    idx    = c[4:0] - 5'd1;
    first  = (ph == PH_WORDGAP) || (ph == PH_DONE);
    if ((c inside {[CH_UP_A:CH_UP_Z]}) || (c inside {[CH_LO_A:CH_LO_Z]})) begin
      r.pat  = ALPHA_PAT[idx];
      r.left = ALPHA_LEN[idx];
      r.ph   = first ? PH_SYM : PH_LETGAP;
    end else if (c inside {[CH_D0:CH_D9]}) begin
      r.pat  = DIGIT_PAT[c[3:0]];
      r.left = DIGIT_LEN;
      r.ph   = first ? PH_SYM : PH_LETGAP;
    end else begin
      if (c != CH_SPACE) begin
        r.left = '0;
      end
      r.ph = PH_WORDGAP;
    end
    return r;
  endfunction

  logic [UNIT_W-1:0] unit_r;
  ph_t               ph_r, ph_nxt;
  logic [PAT_W-1:0]  pat_r, pat_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic [PER_W-1:0]  per_r, per_nxt;
  logic              run_r, run_nxt;
  logic              key_r, key_nxt;
  logic              sw_r, sw_nxt;
  logic              drop_nxt;

  logic              s1_vld_r;
  logic [1:0]        s1_req_r;
  logic [7:0]        s1_byte_r;
  logic              s1_go, fire;

  logic              out_vld_r;
  logic              out_key_r, out_idle_r, out_sw_r, out_drop_r;

  fifo_ctl_t         fctl;
  fifo_sts_t         fsts;
  logic [7:0]        head_data;

  logic [UNIT_W-1:0] u;
  logic [PER_W-1:0]  u1, u3, u7;
  kst_t              ks;
  logic [PAT_W-1:0]  pat_sh;
  logic [LEN_W-1:0]  left_dec;

  assign s1_go    = !out_vld_r || !out_stall;
  assign fire     = s1_vld_r && s1_go;
  assign in_stall = s1_vld_r && !s1_go;

  assign u        = (unit_r == '0) ? UNIT_W'(1) : unit_r;
  assign u1       = PER_W'(u);
  assign u3       = {u1[PER_W-2:0], 1'b0} + u1;
  assign u7       = {u1[PER_W-4:0], 3'b000} - u1;
  assign pat_sh   = pat_r >> 1;
  assign left_dec = left_r - 1'b1;

  always_comb begin
    ph_nxt   = ph_r;
    pat_nxt  = pat_r;
    left_nxt = left_r;
    per_nxt  = per_r;
    run_nxt  = run_r;
    key_nxt  = key_r;
    sw_nxt   = sw_r;
    drop_nxt = 1'b0;
    fctl     = '0;
    ks       = load_char(head_data, ph_r, pat_r, left_r);
    if (fire) begin
      case (s1_req_r)
        REQ_BYTE: begin
          if (s1_byte_r == CH_LF || s1_byte_r == CH_CR) begin
            if (!fsts.empty && ph_r == PH_DONE) begin
              fctl.pop = 1'b1;
              ph_nxt   = ks.ph;
              pat_nxt  = ks.pat;
              left_nxt = ks.left;
              per_nxt  = PER_W'(1);
              run_nxt  = 1'b1;
            end
          end else if (s1_byte_r == CH_HASH) begin
            sw_nxt = 1'b1;
          end else if (fsts.full) begin
            drop_nxt = 1'b1;
          end else begin
            fctl.push = 1'b1;
          end
        end
        REQ_TICK: begin
          if (run_r) begin
            if (per_r <= PER_W'(1)) begin
              run_nxt = 1'b1;
              key_nxt = 1'b0;
              case (ph_r)
                PH_SYM: begin
                  per_nxt  = pat_r[0] ? u3 : u1;
                  pat_nxt  = pat_sh;
                  left_nxt = left_dec;
                  key_nxt  = 1'b1;
                  if (left_dec == '0 && fsts.empty) begin
                    ph_nxt = PH_FINAL;
                  end else if (left_dec == '0) begin
                    ks       = load_char(head_data, ph_r, pat_sh, left_dec);
                    fctl.pop = 1'b1;
                    ph_nxt   = ks.ph;
                    pat_nxt  = ks.pat;
                    left_nxt = ks.left;
                  end else begin
                    ph_nxt = PH_SYMGAP;
                  end
                end
                PH_SYMGAP: begin
                  per_nxt = u1;
                  ph_nxt  = PH_SYM;
                end
                PH_LETGAP: begin
                  per_nxt = u3;
                  ph_nxt  = PH_SYM;
                end
                PH_WORDGAP: begin
                  per_nxt = u7;
                  if (!fsts.empty) begin
                    fctl.pop = 1'b1;
                    ph_nxt   = ks.ph;
                    pat_nxt  = ks.pat;
                    left_nxt = ks.left;
                  end else begin
                    ph_nxt = PH_DONE;
                  end
                end
                PH_FINAL: begin
                  per_nxt = u1;
                  ph_nxt  = PH_DONE;
                end
                default: begin
                  per_nxt = '0;
                  run_nxt = 1'b0;
                end
              endcase
            end else begin
              per_nxt = per_r - 1'b1;
            end
          end
        end
        REQ_CLR: begin
          sw_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  mck_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (fctl),
    .wr_data  (s1_byte_r),
    .sts      (fsts),
    .head_data(head_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r    <= UNIT_W'(25);
      ph_r      <= PH_DONE;
      pat_r     <= '0;
      left_r    <= '0;
      per_r     <= '0;
      run_r     <= 1'b0;
      key_r     <= 1'b0;
      sw_r      <= 1'b0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unit_r <= cfg_wr_data;
      end
      ph_r     <= ph_nxt;
      pat_r    <= pat_nxt;
      left_r   <= left_nxt;
      per_r    <= per_nxt;
      run_r    <= run_nxt;
      key_r    <= key_nxt;
      sw_r     <= sw_nxt;
      if (!in_stall) begin
        s1_vld_r <= in_valid;
      end
      if (s1_go) begin
        out_vld_r <= s1_vld_r;
      end
    end
    if (in_valid && !in_stall) begin
      s1_req_r  <= in_req_type;
      s1_byte_r <= in_rx_byte;
    end
    if (fire) begin
      out_key_r  <= key_nxt;
      out_idle_r <= (ph_nxt == PH_DONE);
      out_sw_r   <= sw_nxt;
      out_drop_r <= drop_nxt;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_key_on           = out_key_r;
  assign out_idle             = out_idle_r;
  assign out_switch_requested = out_sw_r;
  assign out_byte_dropped     = out_drop_r;

endmodule

`default_nettype wire

[hw/rtl/mck_checker.sv]
`default_nettype none

module mck_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_key_on,
  input wire logic        out_idle,
  input wire logic        out_switch_requested,
  input wire logic        out_byte_dropped
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_key_on) && $stable(out_idle)
      && $stable(out_switch_requested) && $stable(out_byte_dropped))
    else $error("stalled result changed");

  // input only backs up when a finished result is waiting
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free result register");

  // key is always off once the transmitter is idle
  a_idle_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_idle |-> !out_key_on)
    else $error("key on while idle");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind morse_code_keyer_tx mck_checker u_mck_checker (.*);

`default_nettype wire

[sim/morse_code_keyer_tx_tb.sv]
`default_nettype none

module morse_code_keyer_tx_tb;
  import mck_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [4:0] MORSE_PAT [26] = '{
    5'h02, 5'h01, 5'h05, 5'h01, 5'h00, 5'h04, 5'h03, 5'h00, 5'h00, 5'h0E, 5'h05, 5'h02,
    5'h03, 5'h01, 5'h07, 5'h06, 5'h0B, 5'h02, 5'h00, 5'h01, 5'h04, 5'h08, 5'h06, 5'h09,
    5'h0D, 5'h03
  };
  localparam logic [2:0] MORSE_LEN [26] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };
  localparam logic [4:0] NUM_PAT [10] = '{
    5'h1F, 5'h1E, 5'h1C, 5'h18, 5'h10, 5'h00, 5'h01, 5'h03, 5'h07, 5'h0F
  };

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] data;
  } keyer_item_t;

  typedef struct {
    logic key_on;
    logic idle;
    logic switch_req;
    logic dropped;
  } keyer_levels_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [11:0] cfg_wr_data = 12'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = REQ_BYTE;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_key_on;
  logic        out_idle;
  logic        out_switch_requested;
  logic        out_byte_dropped;

  morse_code_keyer_tx uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_key_on           (out_key_on),
    .out_idle             (out_idle),
    .out_switch_requested (out_switch_requested),
    .out_byte_dropped     (out_byte_dropped)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // keyer state as the testbench sees it
  logic [11:0] unit_cfg;
  ph_t         tx_ph;
  logic [4:0]  sym_pat;
  logic [2:0]  syms_left;
  logic [14:0] ticks_left;
  logic        timer_on;
  logic        key_lvl;
  logic [7:0]  char_mem [FIFO_DEPTH];
  int          fifo_rd;
  int          fifo_wr;
  int          fifo_cnt;
  logic        sw_flag;

  keyer_item_t   pending_items [$];
  keyer_levels_t expected_levels [$];

  int n_errors = 0;
  int n_queued = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_drops = 0;
  int n_key_on = 0;
  int n_starts = 0;
  int idle_cycles = 0;

  function void reset_keyer_state();
    unit_cfg   = 12'd25;
    tx_ph      = PH_DONE;
    sym_pat    = '0;
    syms_left  = '0;
    ticks_left = '0;
    timer_on   = 1'b0;
    key_lvl    = 1'b0;
    fifo_rd    = 0;
    fifo_wr    = 0;
    fifo_cnt   = 0;
    sw_flag    = 1'b0;
  endfunction

  function logic [7:0] fifo_take();
    logic [7:0] c;
    c = char_mem[fifo_rd];
    fifo_rd = (fifo_rd + 1) % FIFO_DEPTH;
    fifo_cnt--;
    return c;
  endfunction

  function void load_char(input logic [7:0] c);
    logic known;
    known = 1'b1;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      sym_pat = MORSE_PAT[c - CH_UP_A];
      syms_left = MORSE_LEN[c - CH_UP_A];
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      sym_pat = MORSE_PAT[c - CH_LO_A];
      syms_left = MORSE_LEN[c - CH_LO_A];
    end else if (c >= CH_D0 && c <= CH_D9) begin
      sym_pat = NUM_PAT[c - CH_D0];
      syms_left = 3'd5;
    end else begin
      known = 1'b0;
      if (c != CH_SPACE) syms_left = '0;
      tx_ph = PH_WORDGAP;
    end
    if (known) begin
      tx_ph = (tx_ph == PH_WORDGAP || tx_ph == PH_DONE) ? PH_SYM : PH_LETGAP;
    end
  endfunction

  function void timer_expired();
    int u;
    int period;
    logic rearm;
    u = (unit_cfg == 0) ? 1 : int'(unit_cfg);
    period = 0;
    rearm = 1'b1;
    case (tx_ph)
      PH_SYM: begin
        period = sym_pat[0] ? 3 * u : u;
        sym_pat = sym_pat >> 1;
        syms_left = syms_left - 3'd1;
        if (syms_left == 0 && fifo_cnt == 0) tx_ph = PH_FINAL;
        else if (syms_left == 0) load_char(fifo_take());
        else tx_ph = PH_SYMGAP;
        key_lvl = 1'b1;
      end
      PH_SYMGAP: begin
        period = u;
        tx_ph = PH_SYM;
        key_lvl = 1'b0;
      end
      PH_LETGAP: begin
        period = 3 * u;
        tx_ph = PH_SYM;
        key_lvl = 1'b0;
      end
      PH_WORDGAP: begin
        period = 7 * u;
        if (fifo_cnt != 0) load_char(fifo_take());
        else tx_ph = PH_DONE;
        key_lvl = 1'b0;
      end
      PH_FINAL: begin
        period = u;
        tx_ph = PH_DONE;
        key_lvl = 1'b0;
      end
      default: begin
        key_lvl = 1'b0;
        timer_on = 1'b0;
        ticks_left = '0;
        rearm = 1'b0;
      end
    endcase
    if (rearm) begin
      ticks_left = period[14:0];
      timer_on = 1'b1;
    end
  endfunction

  function void predict_keyer_step(input logic [1:0] req, input logic [7:0] b);
    keyer_levels_t r;
    r.dropped = 1'b0;
    case (req)
      REQ_BYTE: begin
        if (b == CH_LF || b == CH_CR) begin
          if (fifo_cnt != 0 && tx_ph == PH_DONE) begin
            load_char(fifo_take());
            ticks_left = 15'd1;
            timer_on = 1'b1;
            n_starts++;
          end
        end else if (b == CH_HASH) begin
          sw_flag = 1'b1;
        end else if (fifo_cnt >= FIFO_DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          char_mem[fifo_wr] = b;
          fifo_wr = (fifo_wr + 1) % FIFO_DEPTH;
          fifo_cnt++;
        end
      end
      REQ_TICK: begin
        if (timer_on) begin
          if (ticks_left <= 1) begin
            ticks_left = '0;
            timer_expired();
          end else begin
            ticks_left = ticks_left - 15'd1;
          end
        end
      end
      REQ_CLR: sw_flag = 1'b0;
      default: ;
    endcase
    r.key_on = key_lvl;
    r.idle = (tx_ph == PH_DONE);
    r.switch_req = sw_flag;
    expected_levels.push_back(r);
  endfunction

  task report_mismatch(input string what, input logic got, input logic want);
    if (n_errors < 40) begin
      $display("mismatch at result %0d: %s got %b expected %b", n_checked, what, got, want);
    end
    n_errors++;
  endtask

  // sender: bursts of items with random gaps
  int burst_left = 8;
  int gap_left = 0;
  keyer_item_t next_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_keyer_step(in_req_type, in_rx_byte);
        n_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_req_type <= next_item.req;
          in_rx_byte <= next_item.data;
          burst_left--;
          if (burst_left <= 0) begin
            gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches mode at the end of each random span
  int stall_mode = 0;
  int stall_span = 0;
  int stall_phase = 0;
  keyer_levels_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_levels.size() == 0) begin
          report_mismatch("result with nothing expected, key_on", out_key_on, 1'bx);
        end else begin
          want = expected_levels.pop_front();
          if (out_key_on !== want.key_on) report_mismatch("key_on", out_key_on, want.key_on);
          if (out_idle !== want.idle) report_mismatch("idle", out_idle, want.idle);
          if (out_switch_requested !== want.switch_req) begin
            report_mismatch("switch_requested", out_switch_requested, want.switch_req);
          end
          if (out_byte_dropped !== want.dropped) begin
            report_mismatch("byte_dropped", out_byte_dropped, want.dropped);
          end
          if (want.dropped) n_drops++;
          if (want.key_on) n_key_on++;
        end
        n_checked++;
      end
      if (stall_span == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_span = $urandom_range(20, 120);
      end else begin
        stall_span--;
      end
      stall_phase++;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: out_stall <= ((stall_phase % 7) < 3);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task add_item(input logic [1:0] req, input logic [7:0] b);
    keyer_item_t it;
    it.req = req;
    it.data = b;
    pending_items.push_back(it);
    n_queued++;
  endtask

  task add_noise();
    case ($urandom_range(0, 5))
      0: add_item(REQ_BYTE, 8'($urandom_range(0, 255)));
      1: add_item(REQ_BYTE, CH_HASH);
      2: add_item(REQ_CLR, 8'($urandom_range(0, 255)));
      3: add_item(REQ_NONE, 8'($urandom_range(0, 255)));
      4: add_item(REQ_BYTE, CH_UP_A + 8'($urandom_range(0, 25)));
      default: add_item(REQ_BYTE, CH_CR);
    endcase
  endtask

  task add_ticks(input int n, input int noise_pct);
    for (int i = 0; i < n; i++) begin
      add_item(REQ_TICK, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < noise_pct) add_noise();
    end
  endtask

  function logic [7:0] random_char();
    logic [7:0] c;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) c = CH_UP_A + 8'($urandom_range(0, 25));
    else if (pick < 6) c = CH_LO_A + 8'($urandom_range(0, 25));
    else if (pick < 8) c = CH_D0 + 8'($urandom_range(0, 9));
    else if (pick == 8) c = CH_SPACE;
    else begin
      do c = 8'($urandom_range(0, 255));
      while (c == CH_LF || c == CH_CR || c == CH_HASH);
    end
    return c;
  endfunction

  // one to four characters, then mostly a start byte and ticks to key them out, sometimes cut short
  task add_message(input int u);
    logic [7:0] c;
    int n;
    int units;
    int ticks;
    n = $urandom_range(1, 4);
    units = 2;
    for (int i = 0; i < n; i++) begin
      c = random_char();
      add_item(REQ_BYTE, c);
      if ((c >= CH_D0 && c <= CH_D9) || (c >= CH_UP_A && c <= CH_UP_Z) ||
          (c >= CH_LO_A && c <= CH_LO_Z)) units += 23;
      else units += 8;
    end
    if ($urandom_range(0, 9) == 0) return;
    add_item(REQ_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF);
    ticks = units * u + 4;
    if ($urandom_range(0, 3) == 0) ticks = $urandom_range(1, ticks);
    add_ticks(ticks, 5);
  endtask

  // overrun the character queue, then key the start of the backlog out
  task add_overflow();
    for (int i = 0; i < FIFO_DEPTH + 6; i++) begin
      if ($urandom_range(0, 7) == 0) add_item(REQ_BYTE, CH_UP_A + 8'd4);
      else if ($urandom_range(0, 1) == 0) add_item(REQ_BYTE, CH_SPACE);
      else add_item(REQ_BYTE, 8'($urandom_range(128, 255)));
    end
    add_item(REQ_BYTE, CH_CR);
    add_ticks(60, 0);
  endtask

  task run_random(input int budget, input int u);
    int stop_at;
    stop_at = n_queued + budget;
    while (n_queued < stop_at) begin
      if ($urandom_range(0, 99) < 85) add_message(u);
      else repeat ($urandom_range(1, 5)) add_noise();
    end
  endtask

  task wait_all_done();
    while (pending_items.size() != 0 || in_valid || expected_levels.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task write_unit(input logic [11:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    unit_cfg = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    reset_keyer_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset unit length
    add_item(REQ_BYTE, CH_UP_A + 8'd4);
    add_item(REQ_BYTE, CH_LF);
    add_ticks(60, 0);
    wait_all_done();

    write_unit(12'd1);
    add_item(REQ_TICK, 8'h00);
    add_item(REQ_BYTE, CH_LF);
    add_item(REQ_BYTE, CH_HASH);
    add_item(REQ_CLR, 8'hFF);
    add_item(REQ_NONE, 8'hFF);
    add_item(REQ_BYTE, CH_UP_A);
    add_item(REQ_BYTE, CH_LO_Z);
    add_item(REQ_BYTE, CH_D0);
    add_item(REQ_BYTE, CH_D9);
    add_item(REQ_BYTE, CH_SPACE);
    add_item(REQ_BYTE, 8'hFF);
    add_item(REQ_BYTE, 8'h00);
    add_item(REQ_BYTE, CH_LO_A + 8'd16);
    add_item(REQ_BYTE, CH_CR);
    add_item(REQ_BYTE, CH_LF);
    add_item(REQ_BYTE, CH_CR);
    add_ticks(60, 0);
    add_item(REQ_BYTE, CH_HASH);
    add_item(REQ_NONE, 8'h00);
    add_ticks(100, 0);
    add_item(REQ_CLR, 8'h00);
    wait_all_done();

    run_random(80, 1);
    add_overflow();
    wait_all_done();

    write_unit(12'd0);
    run_random(60, 1);
    wait_all_done();

    write_unit(12'd2);
    run_random(40, 2);
    wait_all_done();

    // longest unit: a dot keyed on and held
    write_unit(12'd4095);
    add_item(REQ_BYTE, CH_UP_A + 8'd4);
    add_item(REQ_BYTE, CH_CR);
    add_ticks(30, 0);
    add_item(REQ_BYTE, CH_HASH);
    add_ticks(10, 0);
    add_item(REQ_CLR, 8'h00);
    add_ticks(3, 0);
    wait_all_done();

    if (expected_levels.size() != 0) begin
      report_mismatch("results missing at end, key_on", 1'bx, expected_levels[0].key_on);
    end
    $display("%0d items sent over unit lengths 25, 1, 0, 2 and 4095; %0d results checked",
             n_sent, n_checked);
    $display("%0d transmissions started, %0d bytes dropped on a full queue, %0d key-on results",
             n_starts, n_drops, n_key_on);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/mck_pkg.sv
hw/rtl/mck_ram.sv
hw/rtl/mck_fifo.sv
hw/rtl/morse_code_keyer_tx.sv
hw/rtl/mck_checker.sv
sim/morse_code_keyer_tx_tb.sv
